// File: hw/rtl/fobs_pkg.sv
// Shared types, codes and constants of the flash-or-RAM byte store.
`timescale 1ns / 1ps

package fobs_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int MAX_BURST_DEF = 64;

    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 17;
    localparam int OFF_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int ST_W      = 3;
    localparam int SECT_W    = 17;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0]    ERASED          = 8'hFF;
    localparam logic [SECT_W-1:0]    SECTOR_RESET    = 17'd4096;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_ERASE = 2'd2
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_RANGE      = 3'd1,
        ST_ADDR_ALIGN = 3'd2,
        ST_LEN_ALIGN  = 3'd3,
        ST_REFUSED    = 3'd4
    } t_status;

    typedef struct packed {
        logic    capture;
        logic    step;
        logic    mem_we;
        logic    wr_ff;
        logic    use_pos;
        logic    rd_issue;
        logic    wr_begin;
        logic    wr_update;
        logic    div_start;
        logic    div_len;
        logic    emit;
        logic    emit_wr;
        t_status emit_st;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  in_range;
        logic  len_zero;
        logic  len_gt_burst;
        logic  off_ge_len;
        logic  off_last;
        logic  addr_gt_mem;
        logic  flash;
        logic  sect_zero;
        logic  cnt_one;
        logic  clr_last;
        logic  div_done;
        logic  rem_zero;
    } t_dp_sts;

endpackage

// File: hw/rtl/fobs_rem.sv
// Bit-serial remainder unit used for the sector alignment checks.
`timescale 1ns / 1ps

module fobs_rem import fobs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SECT_W-1:0] i_dividend,
    input  logic [SECT_W-1:0] i_divisor,
    output logic              o_done,
    output logic              o_rem_zero
);

    localparam int STEP_W = $clog2(SECT_W + 1);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SECT_W-1:0] r_dvd;
    logic [SECT_W-1:0] r_rem;
    logic [SECT_W:0]   w_trial;
    logic [SECT_W:0]   w_diff;
    logic [SECT_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[SECT_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = w_diff[SECT_W-1:0];
        end else begin
            n_rem = w_trial[SECT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
            end else if (r_run) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[SECT_W-2:0], 1'b0};
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SECT_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

// File: hw/rtl/fobs_ctrl.sv
// Controller state machine that sequences reads, writes, erases and the clearing pass.
`timescale 1ns / 1ps

module fobs_ctrl import fobs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_W_CHK,
        S_W_RES,
        S_E_DIVA,
        S_E_DIVL,
        S_FILL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.emit_st = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wr_ff  = 1'b1;
                o_cmd.step   = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.kind)
                    KIND_READ: begin
                        if (!i_sts.in_range) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.emit_st = ST_RANGE;
                            n_state       = S_IDLE;
                        end else if (i_sts.len_gt_burst) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.emit_st = ST_REFUSED;
                            n_state       = S_IDLE;
                        end else if (i_sts.len_zero) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    KIND_WRITE: begin
                        o_cmd.use_pos = 1'b1;
                        if (i_sts.len_zero) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.emit_st = i_sts.addr_gt_mem ? ST_RANGE : ST_OK;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.wr_begin = 1'b1;
                            n_state        = i_sts.off_ge_len ? S_IDLE : S_W_CHK;
                        end
                    end
                    KIND_ERASE: begin
                        if (!i_sts.in_range) begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.emit_st = ST_RANGE;
                            n_state       = S_IDLE;
                        end else if (i_sts.flash) begin
                            if (i_sts.sect_zero) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.emit_st = ST_ADDR_ALIGN;
                                n_state       = S_IDLE;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_E_DIVA;
                            end
                        end else if (i_sts.len_zero) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_FILL;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.step     = 1'b1;
                if (i_sts.cnt_one) begin
                    n_state = S_IDLE;
                end
            end
            S_W_CHK: begin
                o_cmd.use_pos   = 1'b1;
                o_cmd.wr_update = 1'b1;
                n_state         = i_sts.off_last ? S_W_RES : S_IDLE;
            end
            S_W_RES: begin
                o_cmd.emit    = 1'b1;
                o_cmd.emit_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_E_DIVA: begin
                if (i_sts.div_done) begin
                    if (!i_sts.rem_zero) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.emit_st = ST_ADDR_ALIGN;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_len   = 1'b1;
                        n_state         = S_E_DIVL;
                    end
                end
            end
            S_E_DIVL: begin
                if (i_sts.div_done) begin
                    if (!i_sts.rem_zero) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.emit_st = ST_LEN_ALIGN;
                        n_state       = S_IDLE;
                    end else if (i_sts.len_zero) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wr_ff  = 1'b1;
                o_cmd.step   = 1'b1;
                if (i_sts.cnt_one) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// File: hw/rtl/fobs_dpath.sv
// Datapath with the byte store memory, item registers, write tracking and result registers.
`timescale 1ns / 1ps

module fobs_dpath import fobs_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [LEN_W-1:0]     i_length,
    input  logic [OFF_W-1:0]     i_byte_offset,
    input  logic [BYTE_W-1:0]    i_write_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SECT_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    output logic [BYTE_W-1:0]    o_read_byte,
    output logic [ST_W-1:0]      o_status,
    output logic [LEN_W-1:0]     o_written_count,
    output logic                 o_last
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int END_W = (AW + 2 > LEN_W + 1) ? AW + 2 : LEN_W + 1;

    logic [BYTE_W-1:0] r_mem [MEM_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    t_kind             r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [OFF_W-1:0]  r_off;
    logic [BYTE_W-1:0] r_data;
    logic [END_W-1:0]  r_ptr;
    logic [LEN_W-1:0]  r_cnt;

    logic              r_flash;
    logic [SECT_W-1:0] r_sector;

    logic [LEN_W-1:0]  r_progress;
    logic              r_halted;
    t_status           r_fault;

    logic              r_out_valid;
    logic              r_out_rd;
    t_status           r_out_status;
    logic [LEN_W-1:0]  r_out_count;
    logic              r_out_last;

    logic [END_W-1:0]  w_end;
    logic [END_W-1:0]  w_pos;
    logic              w_in_range;
    logic              w_wr_ok;
    logic              w_mem_we;
    logic [AW-1:0]     w_idx;
    logic [BYTE_W-1:0] w_wdata;
    logic [SECT_W-1:0] w_dividend;
    logic              w_div_done;
    logic              w_rem_zero;

    always_comb begin
        w_end      = END_W'(r_addr) + END_W'(r_len);
        w_pos      = END_W'(r_addr) + END_W'(r_off);
        w_in_range = (w_end <= END_W'(MEM_BYTES));
        w_wr_ok    = !r_halted && w_in_range && !(r_flash && (r_rdata != ERASED));
        w_mem_we   = i_cmd.mem_we || (i_cmd.wr_update && w_wr_ok);
        w_idx      = i_cmd.use_pos ? w_pos[AW-1:0] : r_ptr[AW-1:0];
        w_wdata    = i_cmd.wr_ff ? ERASED : r_data;
        w_dividend = i_cmd.div_len ? r_len : SECT_W'(r_addr);
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_idx] <= w_wdata;
        end
        r_rdata <= r_mem[w_idx];
    end

    fobs_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_sector),
        .o_done     (w_div_done),
        .o_rem_zero (w_rem_zero)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_addr <= i_address;
            r_len  <= i_length;
            r_off  <= i_byte_offset;
            r_data <= i_write_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_cnt      <= '0;
            r_flash    <= 1'b0;
            r_sector   <= SECTOR_RESET;
            r_progress <= '0;
            r_halted   <= 1'b0;
            r_fault    <= ST_OK;
        end else begin
            if (i_cmd.capture) begin
                r_ptr <= END_W'(i_address);
                r_cnt <= i_length;
            end else if (i_cmd.step) begin
                r_ptr <= r_ptr + END_W'(1);
                r_cnt <= r_cnt - LEN_W'(1);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FLASH_MODE) begin
                    r_flash <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_SECTOR_SIZE) begin
                    r_sector <= i_cfg_data;
                end
            end
            if (i_cmd.wr_begin && (r_off == '0)) begin
                r_progress <= '0;
                r_halted   <= 1'b0;
                r_fault    <= ST_OK;
            end else if (i_cmd.wr_update && !r_halted) begin
                if (!w_in_range) begin
                    r_halted <= 1'b1;
                    r_fault  <= ST_RANGE;
                end else if (r_flash && (r_rdata != ERASED)) begin
                    r_halted <= 1'b1;
                    r_fault  <= ST_REFUSED;
                end else if (r_progress != '1) begin
                    r_progress <= r_progress + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_rd    <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.rd_issue || i_cmd.emit;
            r_out_rd    <= i_cmd.rd_issue;
            if (i_cmd.rd_issue) begin
                r_out_status <= ST_OK;
                r_out_count  <= '0;
                r_out_last   <= (r_cnt == LEN_W'(1));
            end else if (i_cmd.emit) begin
                r_out_status <= i_cmd.emit_wr ? r_fault : i_cmd.emit_st;
                r_out_count  <= i_cmd.emit_wr ? r_progress : '0;
                r_out_last   <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.kind         = r_kind;
        o_sts.in_range     = w_in_range;
        o_sts.len_zero     = (r_len == '0);
        o_sts.len_gt_burst = (r_len > LEN_W'(MAX_BURST));
        o_sts.off_ge_len   = (LEN_W'(r_off) >= r_len);
        o_sts.off_last     = ((LEN_W'(r_off) + LEN_W'(1)) == r_len);
        o_sts.addr_gt_mem  = (END_W'(r_addr) > END_W'(MEM_BYTES));
        o_sts.flash        = r_flash;
        o_sts.sect_zero    = (r_sector == '0);
        o_sts.cnt_one      = (r_cnt == LEN_W'(1));
        o_sts.clr_last     = (r_ptr == END_W'(MEM_BYTES - 1));
        o_sts.div_done     = w_div_done;
        o_sts.rem_zero     = w_rem_zero;
    end

    assign o_valid         = r_out_valid;
    assign o_read_byte     = r_out_rd ? r_rdata : '0;
    assign o_status        = r_out_status;
    assign o_written_count = r_out_count;
    assign o_last          = r_out_last;

endmodule

// File: hw/rtl/flash_or_ram_byte_store.sv
// Top level of the byte store that acts as plain RAM or as NOR flash.
//
//   Channel   Handshake                   Payload
//   item      start, busy                 i_kind, i_address, i_length, i_byte_offset,
//                                         i_write_byte
//   config    i_cfg_valid, o_cfg_ready    i_cfg_index, i_cfg_data
//   result    o_valid (one-cycle strobe)  o_read_byte, o_status, o_written_count, o_last
//
// An item is taken when start is high and busy is low; busy is high until it is done.
// A read returns one byte per cycle, or gives a status only when it is refused.
// A write checks and writes one byte; on an access's final byte it gives the result.
// An erase fills length bytes, or ends when refused; in flash mode each of the two
// sector checks runs on the bit-serial remainder unit, and a failed one ends it.
// After reset busy is high while the store fills with 0xFF; results
// cannot be stalled by the receiver.
`timescale 1ns / 1ps

module flash_or_ram_byte_store import fobs_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic [LEN_W-1:0]     i_length,
    input  logic [OFF_W-1:0]     i_byte_offset,
    input  logic [BYTE_W-1:0]    i_write_byte,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SECT_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    output logic [BYTE_W-1:0]    o_read_byte,
    output logic [ST_W-1:0]      o_status,
    output logic [LEN_W-1:0]     o_written_count,
    output logic                 o_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    fobs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    fobs_dpath #(
        .MEM_BYTES (MEM_BYTES),
        .MAX_BURST (MAX_BURST)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (i_kind),
        .i_address       (i_address),
        .i_length        (i_length),
        .i_byte_offset   (i_byte_offset),
        .i_write_byte    (i_write_byte),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_read_byte     (o_read_byte),
        .o_status        (o_status),
        .o_written_count (o_written_count),
        .o_last          (o_last)
    );

endmodule
